FILE: rtl/spjq_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and codes of the sorted priority job queue.
package spjq_pkg;

   // Number of cells in the chain, one queued job per cell.
   localparam int CAPACITY = 64;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   // Width at which a request position is compared with the job count.
   localparam int CMP_W = (CNT_W > 6) ? CNT_W : 6;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_REMOVE = 2'd1,
      CMD_UPDATE = 2'd2,
      CMD_CLEAR  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] pages;
      logic [15:0] tag;
   } job_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_POP,
      CELL_REPRIO,
      CELL_SETTLE
   } cell_op_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      cell_op_type            op;
      job_type                job;
      logic [CNT_W-1:0]       count;
      logic [IDX_W-1:0]       index;
   } cell_ctl_type;

   // Reported from the chain back to the controller while a job settles.
   typedef struct packed {
      logic swap_right;
      logic swap_left;
   } chain_status_type;

   typedef enum logic {
      ST_IDLE,
      ST_SETTLE
   } state_type;

endpackage

FILE: rtl/spjq_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the sorted priority job queue.
interface spjq_req_if;
   import spjq_pkg::*;

   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [7:0]  priority_req;
   logic [15:0] pages;
   logic [15:0] job_tag;
   logic [5:0]  position;

   modport source (output valid, output cmd, output priority_req, output pages,
                   output job_tag, output position, input ready);
   modport sink (input valid, input cmd, input priority_req, input pages,
                 input job_tag, input position, output ready);
endinterface

interface spjq_rsp_if;
   import spjq_pkg::*;

   logic        valid;
   logic        ready;
   logic        ok;
   logic [7:0]  out_priority;
   logic [15:0] out_pages;
   logic [15:0] out_tag;
   logic [6:0]  count;

   modport source (output valid, output ok, output out_priority, output out_pages,
                   output out_tag, output count, input ready);
   modport sink (input valid, input ok, input out_priority, input out_pages,
                 input out_tag, input count, output ready);
endinterface

FILE: rtl/sorted_priority_job_queue.sv
`timescale 1ns / 1ps
// Sorted priority job queue: a chain of job cells kept in descending priority order.
//
// The queue holds up to CAPACITY jobs in a row of cells, head first, sorted by
// descending priority, with jobs of equal priority in arrival order. Every
// request transaction produces exactly one response transaction carrying ok,
// the removed job (zero unless a remove succeeded) and the job count after the
// command. Insert, remove and clear finish in the cycle the request is taken:
// all cells compare the new priority in parallel and shift by one place, and
// the response is registered at that same edge, so a new request can be taken
// on the very next cycle, provided the previous response is taken at that same
// edge. An update rewrites the priority of the job at the given position and
// then lets that job walk to its new place by swapping with one neighbor per
// cycle; the response is issued at once, but the next request is taken only
// after the walk has ended. The walk covers d positions, where d is the
// distance between the old and the new place of the job (at most CAPACITY - 1).
// The request channel holds off while the response register is full and not
// being drained. The job store has no reset; the job count alone decides which
// cells are occupied.
module sorted_priority_job_queue (
   input logic      clock,
   input logic      reset,
   spjq_req_if.sink   req_ch,
   spjq_rsp_if.source rsp_ch
);
   import spjq_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [IDX_W-1:0] cur_ff, cur_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_ok_ff, rsp_ok_in;
   logic [7:0]       rsp_prio_ff, rsp_prio_in;
   logic [15:0]      rsp_pages_ff, rsp_pages_in;
   logic [15:0]      rsp_tag_ff, rsp_tag_in;
   logic [6:0]       rsp_count_ff, rsp_count_in;

   logic             req_ready;
   logic             accept;
   cell_ctl_type     ctl;
   job_type          head_job;
   chain_status_type status;

   spjq_chain u_chain (
      .clock    (clock),
      .ctl      (ctl),
      .head_job (head_job),
      .status   (status)
   );

   // Controller: decodes the request, drives the cells and builds the response.
   always_comb begin
      req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ch.ready);
      accept    = req_ch.valid && req_ready;

      state_in     = state_ff;
      count_in     = count_ff;
      cur_in       = cur_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_ok_in    = rsp_ok_ff;
      rsp_prio_in  = rsp_prio_ff;
      rsp_pages_in = rsp_pages_ff;
      rsp_tag_in   = rsp_tag_ff;
      rsp_count_in = rsp_count_ff;

      ctl.op        = CELL_HOLD;
      ctl.job.prio  = req_ch.priority_req;
      ctl.job.pages = req_ch.pages;
      ctl.job.tag   = req_ch.job_tag;
      ctl.count     = count_ff;
      ctl.index     = cur_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_ok_in    = 1'b0;
               rsp_prio_in  = '0;
               rsp_pages_in = '0;
               rsp_tag_in   = '0;
               case (cmd_type'(req_ch.cmd))
                  CMD_INSERT: begin
                     if (count_ff < CNT_W'(CAPACITY)) begin
                        ctl.op    = CELL_INSERT;
                        count_in  = count_ff + 1'b1;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  CMD_REMOVE: begin
                     if (count_ff != '0) begin
                        ctl.op       = CELL_POP;
                        count_in     = count_ff - 1'b1;
                        rsp_ok_in    = 1'b1;
                        rsp_prio_in  = head_job.prio;
                        rsp_pages_in = head_job.pages;
                        rsp_tag_in   = head_job.tag;
                     end
                  end
                  CMD_UPDATE: begin
                     // The job keeps its cell for now; the settle walk moves it.
                     if (CMP_W'(req_ch.position) < CMP_W'(count_ff)) begin
                        ctl.op    = CELL_REPRIO;
                        ctl.index = IDX_W'(req_ch.position);
                        cur_in    = IDX_W'(req_ch.position);
                        state_in  = ST_SETTLE;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  CMD_CLEAR: begin
                     if (count_ff != '0) begin
                        count_in  = '0;
                        rsp_ok_in = 1'b1;
                     end
                  end
                  default: begin
                     rsp_ok_in = 1'b0;
                  end
               endcase
               rsp_count_in = 7'(count_in);
            end
         end
         ST_SETTLE: begin
            // Follow the updated job one cell per cycle until it stops moving.
            ctl.op = CELL_SETTLE;
            if (status.swap_right) begin
               cur_in = cur_ff + 1'b1;
            end else if (status.swap_left) begin
               cur_in = cur_ff - 1'b1;
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_ff       <= cur_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff    <= rsp_ok_in;
      rsp_prio_ff  <= rsp_prio_in;
      rsp_pages_ff <= rsp_pages_in;
      rsp_tag_ff   <= rsp_tag_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign req_ch.ready        = req_ready;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.ok           = rsp_ok_ff;
   assign rsp_ch.out_priority = rsp_prio_ff;
   assign rsp_ch.out_pages    = rsp_pages_ff;
   assign rsp_ch.out_tag      = rsp_tag_ff;
   assign rsp_ch.count        = rsp_count_ff;

`ifndef SYNTH
   // The job count never runs past the number of cells.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("job count exceeds capacity");

   // A settling job never asks to move both ways at once.
   a_one_direction: assert property (@(posedge clock) disable iff (reset)
      !(status.swap_right && status.swap_left))
      else $error("settling job swaps in both directions");

   // No new request is taken while an updated job is still walking.
   a_no_accept_settle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SETTLE) |-> !req_ready)
      else $error("request taken during settle walk");

   // An insert into a full queue reports failure.
   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_ch.cmd == CMD_INSERT) && (count_ff == CNT_W'(CAPACITY)))
      |=> (rsp_valid_ff && !rsp_ok_ff))
      else $error("insert into full queue did not fail");
`endif

endmodule

FILE: rtl/spjq_cell.sv
`timescale 1ns / 1ps
// One cell of the job chain: holds a single job and trades it with its neighbors.
module spjq_cell (
   input  logic                      clock,
   input  spjq_pkg::cell_ctl_type    ctl,
   input  logic [spjq_pkg::IDX_W-1:0] index,
   input  spjq_pkg::job_type         left_job,
   input  logic                      left_ge,
   input  logic                      left_swap_r,
   input  spjq_pkg::job_type         right_job,
   input  logic                      right_occ,
   input  logic                      right_swap_l,
   output spjq_pkg::job_type         job,
   output logic                      ge,
   output logic                      occ,
   output logic                      swap_r,
   output logic                      swap_l
);
   import spjq_pkg::*;

   job_type job_ff;
   job_type job_in;
   logic    is_cur;

   always_comb begin
      occ    = CNT_W'(index) < ctl.count;
      ge     = occ && (job_ff.prio >= ctl.job.prio);
      is_cur = (index == ctl.index);
      // The settling job walks toward the tail past jobs of equal or higher
      // priority, and toward the head past jobs of lower priority.
      swap_r = (ctl.op == CELL_SETTLE) && is_cur && right_occ &&
               (right_job.prio >= job_ff.prio);
      swap_l = (ctl.op == CELL_SETTLE) && is_cur && !swap_r &&
               (left_job.prio < job_ff.prio);

      job_in = job_ff;
      case (ctl.op)
         CELL_INSERT: begin
            if (!ge) begin
               job_in = left_ge ? ctl.job : left_job;
            end
         end
         CELL_POP: begin
            job_in = right_job;
         end
         CELL_REPRIO: begin
            if (is_cur) begin
               job_in.prio = ctl.job.prio;
            end
         end
         CELL_SETTLE: begin
            if (swap_r || right_swap_l) begin
               job_in = right_job;
            end else if (swap_l || left_swap_r) begin
               job_in = left_job;
            end
         end
         default: begin
            job_in = job_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   assign job = job_ff;

endmodule

FILE: rtl/spjq_chain.sv
`timescale 1ns / 1ps
// Row of job cells with neighbor wiring, end tie-offs and settle status.
module spjq_chain (
   input  logic                        clock,
   input  spjq_pkg::cell_ctl_type      ctl,
   output spjq_pkg::job_type           head_job,
   output spjq_pkg::chain_status_type  status
);
   import spjq_pkg::*;

   job_type             job [CAPACITY];
   job_type             left_job [CAPACITY];
   job_type             right_job [CAPACITY];
   logic [CAPACITY-1:0] ge;
   logic [CAPACITY-1:0] occ;
   logic [CAPACITY-1:0] swap_r;
   logic [CAPACITY-1:0] swap_l;
   logic [CAPACITY-1:0] left_ge;
   logic [CAPACITY-1:0] left_swap_r;
   logic [CAPACITY-1:0] right_occ;
   logic [CAPACITY-1:0] right_swap_l;

   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_head
         // The head sees a virtual neighbor that outranks every job.
         assign left_job[g]    = '1;
         assign left_ge[g]     = 1'b1;
         assign left_swap_r[g] = 1'b0;
      end else begin : g_inner_l
         assign left_job[g]    = job[g-1];
         assign left_ge[g]     = ge[g-1];
         assign left_swap_r[g] = swap_r[g-1];
      end

      if (g == CAPACITY - 1) begin : g_tail
         assign right_job[g]    = '0;
         assign right_occ[g]    = 1'b0;
         assign right_swap_l[g] = 1'b0;
      end else begin : g_inner_r
         assign right_job[g]    = job[g+1];
         assign right_occ[g]    = occ[g+1];
         assign right_swap_l[g] = swap_l[g+1];
      end

      spjq_cell u_cell (
         .clock        (clock),
         .ctl          (ctl),
         .index        (IDX_W'(g)),
         .left_job     (left_job[g]),
         .left_ge      (left_ge[g]),
         .left_swap_r  (left_swap_r[g]),
         .right_job    (right_job[g]),
         .right_occ    (right_occ[g]),
         .right_swap_l (right_swap_l[g]),
         .job          (job[g]),
         .ge           (ge[g]),
         .occ          (occ[g]),
         .swap_r       (swap_r[g]),
         .swap_l       (swap_l[g])
      );
   end

   assign head_job          = job[0];
   assign status.swap_right = |swap_r;
   assign status.swap_left  = |swap_l;

endmodule
